[design/rlerd_pkg.sv]
// Shared types and constants for the run-length image row decoder.
package rlerd_pkg;

  // Default depth of the queue between the parser and the row tracker.
  localparam int unsigned QueueDepth = 4;

  // Configuration register indexes.
  localparam logic [1:0] CfgCompressed  = 2'd0;
  localparam logic [1:0] CfgImageWidth  = 2'd1;
  localparam logic [1:0] CfgImageHeight = 2'd2;

  // Reset values of the configuration registers.
  localparam logic        CompressedReset  = 1'b1;
  localparam logic [15:0] ImageWidthReset  = 16'd320;
  localparam logic [15:0] ImageHeightReset = 16'd200;

  // Control byte codes.
  localparam logic [7:0] LiteralMax  = 8'h7f;
  localparam logic [7:0] LongRunCode = 8'hff;
  localparam logic [7:0] ShortRunBase = 8'h80;

  typedef enum logic [2:0] {
    PhCtrl  = 3'd0,
    PhLit   = 3'd1,
    PhCntLo = 3'd2,
    PhCntHi = 3'd3,
    PhValue = 3'd4
  } phase_e;

  // One work entry handed from the parser to the row tracker.
  typedef struct packed {
    logic        start;  // a packet begins: advance the column by count
    logic        emit;   // produce one run
    logic        last;   // the run closes its packet
    logic [7:0]  value;
    logic [15:0] count;
  } op_t;

endpackage

[design/rlerd_front.sv]
// Byte parser: walks the packet structure and issues work entries.
module rlerd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             compressed_i,
  input  logic             in_valid_i,
  input  logic [7:0]       data_byte_i,
  input  logic             queue_full_i,
  output logic             push_o,
  output rlerd_pkg::op_t   op_o
);
  import rlerd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [6:0]  lit_left_q, lit_left_d;
  logic [15:0] run_len_q, run_len_d;
  logic        accept;
  logic        has_op;

  assign accept = in_valid_i && !queue_full_i;
  assign push_o = accept && has_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhCtrl;
      lit_left_q <= '0;
      run_len_q  <= '0;
    end else if (accept) begin
      phase_q    <= phase_d;
      lit_left_q <= lit_left_d;
      run_len_q  <= run_len_d;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    lit_left_d = lit_left_q;
    run_len_d  = run_len_q;
    has_op     = 1'b0;
    op_o       = '{start: 1'b0, emit: 1'b0, last: 1'b0,
                   value: data_byte_i, count: 16'd1};
    unique case (phase_q)
      PhLit: begin
        lit_left_d = lit_left_q - 7'd1;
        has_op     = 1'b1;
        op_o.emit  = 1'b1;
        op_o.last  = (lit_left_q == 7'd1);
        if (lit_left_q == 7'd1) begin
          phase_d = PhCtrl;
        end
      end
      PhCntLo: begin
        run_len_d = {8'd0, data_byte_i};
        phase_d   = PhCntHi;
      end
      PhCntHi: begin
        run_len_d = {data_byte_i, run_len_q[7:0]};
        phase_d   = PhValue;
      end
      PhValue: begin
        phase_d    = PhCtrl;
        has_op     = (run_len_q != 16'd0);
        op_o.start = 1'b1;
        op_o.emit  = 1'b1;
        op_o.last  = 1'b1;
        op_o.count = run_len_q;
      end
      default: begin
        phase_d = PhCtrl;
        if (!compressed_i) begin
          has_op     = 1'b1;
          op_o.start = 1'b1;
          op_o.emit  = 1'b1;
          op_o.last  = 1'b1;
        end else if (data_byte_i <= LiteralMax) begin
          if (data_byte_i != 8'd0) begin
            lit_left_d = data_byte_i[6:0];
            has_op     = 1'b1;
            op_o.start = 1'b1;
            op_o.count = {9'd0, data_byte_i[6:0]};
            phase_d    = PhLit;
          end
        end else if (data_byte_i == LongRunCode) begin
          run_len_d = '0;
          phase_d   = PhCntLo;
        end else begin
          run_len_d = {8'd0, data_byte_i - ShortRunBase};
          phase_d   = PhValue;
        end
      end
    endcase
  end

endmodule

[design/rlerd_fifo.sv]
// Small queue of work entries between the parser and the row tracker.
module rlerd_fifo #(
  parameter int unsigned Depth = rlerd_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rlerd_pkg::op_t push_op_i,
  input  logic           pop_i,
  output rlerd_pkg::op_t head_op_o,
  output logic           empty_o,
  output logic           full_o
);
  import rlerd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  op_t             entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign empty_o   = (count_q == '0);
  assign full_o    = (count_q == CntW'(Depth));
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign head_op_o = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill count beyond depth");

endmodule

[design/rlerd_back.sv]
// Row tracker: applies work entries to the column and row counts and drives results.
module rlerd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [15:0]    image_width_i,
  input  logic [15:0]    image_height_i,
  input  logic           empty_i,
  input  rlerd_pkg::op_t head_op_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     pixel_value_o,
  output logic [15:0]    repeat_count_o,
  output logic           row_end_o,
  output logic           image_end_o
);
  import rlerd_pkg::*;

  logic [16:0] column_q, column_d;
  logic [15:0] row_q, row_d;
  logic        ends_row_q, ends_row_d;
  logic        done_q, done_d;
  logic        out_valid_q;
  logic [7:0]  value_q;
  logic [15:0] count_q;
  logic        rend_q, iend_q, rend_d, iend_d;
  logic [16:0] col_start;
  logic [15:0] row_next;
  logic        ends_now;
  logic        load;

  assign pop_o = !empty_i &&
                 (done_q || !head_op_i.emit || !out_valid_q || !out_stall_i);
  assign load  = pop_o && !done_q && head_op_i.emit;

  assign col_start = head_op_i.start ? column_q + {1'b0, head_op_i.count} : column_q;
  assign ends_now  = head_op_i.start ? (col_start >= {1'b0, image_width_i}) : ends_row_q;
  assign row_next  = row_q + 16'd1;

  always_comb begin
    column_d   = column_q;
    row_d      = row_q;
    ends_row_d = ends_row_q;
    done_d     = done_q;
    rend_d     = 1'b0;
    iend_d     = 1'b0;
    if (pop_o && !done_q) begin
      column_d   = col_start;
      ends_row_d = ends_now;
      if (head_op_i.emit && head_op_i.last && ends_now) begin
        rend_d     = 1'b1;
        column_d   = '0;
        row_d      = row_next;
        ends_row_d = 1'b0;
        if (row_next >= image_height_i) begin
          iend_d = 1'b1;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      row_q       <= '0;
      ends_row_q  <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      column_q   <= column_d;
      row_q      <= row_d;
      ends_row_q <= ends_row_d;
      done_q     <= done_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      value_q <= head_op_i.value;
      count_q <= head_op_i.count;
      rend_q  <= rend_d;
      iend_q  <= iend_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_value_o  = value_q;
  assign repeat_count_o = count_q;
  assign row_end_o      = rend_q;
  assign image_end_o    = iend_q;

  a_iend_has_rend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && iend_q |-> rend_q)
    else $error("image end without row end");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> done_q)
    else $error("image end flag cleared without reset");

  a_no_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !out_valid_q |=> !out_valid_q)
    else $error("result produced after image end");

endmodule

[design/rle_image_row_decoder.sv]
// Top level of the run-length image row decoder: configuration registers and block wiring.
//
// The decoder takes the encoded pixel stream of an 8-bit image one byte per transfer and
// produces pixel runs (pixel_value, repeat_count) with row_end and image_end marks. It takes
// one byte every clock cycle while in_stall is low and delivers up to one run every cycle
// while out_stall is low. A byte passes the parser in the cycle it is taken and is written
// into a queue of QueueDepth entries; its run is loaded into the output register at the
// same edge at which the row tracker takes it from the queue. Input stall rises only when
// that queue is full, which happens only after the output side has stalled. Control bytes
// and count bytes give no result. After the last row of the image every byte is taken and
// dropped until reset. Configuration writes take effect at once and are meant for times
// when no transfer is in flight; the compressed bit is looked at only when a packet begins,
// width also when a packet begins, and height when a packet ends.
module rle_image_row_decoder #(
  parameter int unsigned QueueDepth = rlerd_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  pixel_value_o,
  output logic [15:0] repeat_count_o,
  output logic        row_end_o,
  output logic        image_end_o
);
  import rlerd_pkg::*;

  logic        compressed_q;
  logic [15:0] image_width_q;
  logic [15:0] image_height_q;

  logic queue_full, queue_empty, push, pop;
  op_t  push_op, head_op;

  // Configuration registers; an index beyond the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compressed_q   <= CompressedReset;
      image_width_q  <= ImageWidthReset;
      image_height_q <= ImageHeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgCompressed:  compressed_q   <= cfg_data_i[0];
        CfgImageWidth:  image_width_q  <= cfg_data_i;
        CfgImageHeight: image_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = queue_full;

  // The parser classifies every byte and issues work entries for the row tracker.
  rlerd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .compressed_i (compressed_q),
    .in_valid_i   (in_valid_i),
    .data_byte_i  (data_byte_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .op_o         (push_op)
  );

  rlerd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .pop_i     (pop),
    .head_op_o (head_op),
    .empty_o   (queue_empty),
    .full_o    (queue_full)
  );

  // The row tracker keeps the column and row counts and owns the output register.
  rlerd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .empty_i        (queue_empty),
    .head_op_i      (head_op),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_value_o  (pixel_value_o),
    .repeat_count_o (repeat_count_o),
    .row_end_o      (row_end_o),
    .image_end_o    (image_end_o)
  );

endmodule

[tb/sv/tb_rle_image_row_decoder.sv]
// Self-checking testbench for the run-length image row decoder, with its own run predictor.
`timescale 1ns / 1ps

module tb_rle_image_row_decoder;
  import rlerd_pkg::*;

  // Cycles to let pass once the last expected run has arrived. A control or count byte
  // gives no run but may still sit in the internal queue, so the wait covers a full queue.
  localparam int unsigned SettleCycles = 2 * QueueDepth + 4;

  // Generous run limit.
  localparam int unsigned CycleLimit = 200000;

  // Hand-picked opening stream, decoded under the reset register values. It covers the
  // three empty packet forms, a literal with extreme pixel values, the shortest and the
  // longest short repeat, and long repeats of count 65535 and count 1. The long repeat
  // of 65535 runs past the reset width, so it also closes the first row.
  localparam logic [7:0] OpeningBytes [21] = '{
    8'h00,
    8'h80,
    8'hff, 8'h00, 8'h00, 8'h55,
    8'h02, 8'h00, 8'hff,
    8'h81, 8'haa,
    8'hfe, 8'h01,
    8'hff, 8'hff, 8'hff, 8'h7f,
    8'hff, 8'h01, 8'h00, 8'h80
  };

  // One pixel run as it leaves the block.
  typedef struct packed {
    logic [7:0]  value;
    logic [15:0] count;
    logic        row_end;
    logic        image_end;
  } pixel_run_t;

  // Predicts the runs that each accepted byte produces and checks the runs that arrive.
  // It keeps its own copy of the registers and of the parse and row-tracking state.
  class run_scoreboard;
    pixel_run_t  expected_runs[$];
    int unsigned mismatches = 0;

    logic        compressed   = CompressedReset;
    logic [15:0] width        = ImageWidthReset;
    logic [15:0] height       = ImageHeightReset;
    phase_e      phase        = PhCtrl;
    logic [6:0]  literal_left = '0;
    logic [15:0] run_len      = '0;
    logic [16:0] column       = '0;
    logic [15:0] row          = '0;
    logic        ends_row     = 1'b0;
    logic        done         = 1'b0;

    function void write_reg(logic [1:0] index, logic [15:0] data);
      case (index)
        CfgCompressed:  compressed = data[0];
        CfgImageWidth:  width = data;
        CfgImageHeight: height = data;
        default: ;
      endcase
    endfunction

    // A non-empty packet moves the column, and the row-end test is latched right away.
    function void open_packet(logic [15:0] len);
      column   = column + {1'b0, len};
      ends_row = column >= {1'b0, width};
    endfunction

    // Queues one expected run. Only the run that closes a packet can close a row.
    function void add_run(logic [7:0] value, logic [15:0] count, logic last);
      pixel_run_t run;
      run.value     = value;
      run.count     = count;
      run.row_end   = 1'b0;
      run.image_end = 1'b0;
      if (last && ends_row) begin
        run.row_end = 1'b1;
        column      = '0;
        row         = row + 16'd1;
        if (row >= height) begin
          run.image_end = 1'b1;
          done          = 1'b1;
        end
        ends_row = 1'b0;
      end
      expected_runs.push_back(run);
    endfunction

    function void note_byte(logic [7:0] b);
      if (done) return;
      case (phase)
        PhLit: begin
          literal_left = literal_left - 7'd1;
          if (literal_left == 0) phase = PhCtrl;
          add_run(b, 16'd1, literal_left == 0);
        end
        PhCntLo: begin
          run_len = {8'h00, b};
          phase   = PhCntHi;
        end
        PhCntHi: begin
          run_len[15:8] = b;
          phase         = PhValue;
        end
        PhValue: begin
          phase = PhCtrl;
          if (run_len != 0) begin
            open_packet(run_len);
            add_run(b, run_len, 1'b1);
          end
        end
        default: begin
          // The mode is looked at only here, when a packet begins.
          phase = PhCtrl;
          if (!compressed) begin
            open_packet(16'd1);
            add_run(b, 16'd1, 1'b1);
          end else if (b <= LiteralMax) begin
            if (b != 0) begin
              literal_left = b[6:0];
              open_packet({8'h00, b});
              phase = PhLit;
            end
          end else if (b == LongRunCode) begin
            run_len = '0;
            phase   = PhCntLo;
          end else begin
            run_len = {8'h00, b - ShortRunBase};
            phase   = PhValue;
          end
        end
      endcase
    endfunction

    function void check_run(pixel_run_t got);
      pixel_run_t want;
      if (expected_runs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected run: value %02h count %0d row_end %0b image_end %0b",
                   got.value, got.count, got.row_end, got.image_end);
        return;
      end
      want = expected_runs.pop_front();
      if (got.value !== want.value || got.count !== want.count ||
          got.row_end !== want.row_end || got.image_end !== want.image_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("run mismatch: expected %02h/%0d/%0b/%0b, got %02h/%0d/%0b/%0b",
                   want.value, want.count, want.row_end, want.image_end,
                   got.value, got.count, got.row_end, got.image_end);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [1:0]  cfg_index_i    = CfgCompressed;
  logic [15:0] cfg_data_i     = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [7:0]  pixel_value_o;
  logic [15:0] repeat_count_o;
  logic        row_end_o;
  logic        image_end_o;

  // While this is set, neither side idles nor stalls.
  bit          calm       = 1'b0;
  int unsigned bytes_sent = 0;

  run_scoreboard sb = new();

  rle_image_row_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_value_o  (pixel_value_o),
    .repeat_count_o (repeat_count_o),
    .row_end_o      (row_end_o),
    .image_end_o    (image_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The receiver stalls with a chance of about 11 percent. Stall changes at the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 11);
  end

  // A run is taken at the rising edge where valid is high and stall is low.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_run('{pixel_value_o, repeat_count_o, row_end_o, image_end_o});
  end

  // Ends a run that hangs.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  // Sends one byte. It is called at a falling edge and returns at one, with valid still
  // high, so that back-to-back transfers keep valid up without a glitch. Before the byte
  // the sender may idle unless calm is set.
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 11) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Drops valid, waits until every expected run has arrived, then lets the internal
  // queue drain of bytes that give no run. The block is idle afterwards.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected_runs.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Writes all three registers in consecutive cycles. Called only while the block is idle.
  task automatic set_regs(input logic comp, input logic [15:0] w, input logic [15:0] h);
    logic [15:0] values [3];
    values[CfgCompressed]  = {15'd0, comp};
    values[CfgImageWidth]  = w;
    values[CfgImageHeight] = h;
    for (int i = 0; i < 3; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= 2'(i);
      cfg_data_i  <= values[i];
      @(posedge clk_i);
      sb.write_reg(2'(i), values[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_literal(input int unsigned len);
    send_byte(8'(len));
    repeat (len) send_byte(8'($urandom_range(0, 255)));
  endtask

  // One random packet in the current mode. Most packets are well formed with random
  // content; a few are empty and a few are a lone random byte that may break the framing.
  task automatic send_packet();
    int unsigned pick;
    logic [15:0] run;
    pick = $urandom_range(0, 99);
    if (!sb.compressed) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 35) begin
      send_literal(($urandom_range(0, 19) == 0) ? $urandom_range(1, 127)
                                               : $urandom_range(1, 6));
    end else if (pick < 65) begin
      send_byte(8'($urandom_range(ShortRunBase + 1, LongRunCode - 1)));
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 85) begin
      case ($urandom_range(0, 3))
        0: run = 16'($urandom_range(1, 300));
        1: run = 16'($urandom);
        2: run = 16'hffff;
        default: run = 16'h0000;
      endcase
      send_byte(LongRunCode);
      send_byte(run[7:0]);
      send_byte(run[15:8]);
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 93) begin
      send_byte(pick[0] ? ShortRunBase : 8'h00);
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    int unsigned phase_idx;
    int unsigned phase_end;
    int unsigned guard;
    logic [15:0] width_pick;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (OpeningBytes[i]) send_byte(OpeningBytes[i]);

    // A literal that begins in compressed mode keeps going after the mode is switched off
    // in its middle; only then do bytes pass through raw, control codes included.
    send_byte(8'h03);
    send_byte(8'h11);
    settle();
    set_regs(1'b0, ImageWidthReset, ImageHeightReset);
    send_byte(8'h22);
    send_byte(8'h33);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h80);

    // The longest literal, then random phases. The height stays at its top so that the
    // image does not end before the last phase. Width and mode change from phase to
    // phase, so some changes land while a row is half filled.
    settle();
    set_regs(1'b1, 16'hffff, 16'hffff);
    send_literal(127);
    for (phase_idx = 0; phase_idx < 8; phase_idx++) begin
      case (phase_idx % 4)
        0: width_pick = 16'd1;
        1: width_pick = 16'hffff;
        2: width_pick = 16'($urandom_range(2, 64));
        default: width_pick = 16'($urandom_range(1, 65535));
      endcase
      settle();
      set_regs(phase_idx % 3 != 1, width_pick, 16'hffff);
      calm = (phase_idx == 3);
      phase_end = bytes_sent + 60;
      while (bytes_sent < phase_end) begin
        send_packet();
        // Now and then the sender holds off until the output side has caught up.
        if ($urandom_range(0, 49) == 0) settle();
      end
    end
    calm = 1'b0;

    // The row count is already past a height of one, so the next row end closes the image.
    settle();
    set_regs(1'b1, 16'd8, 16'd1);
    guard = 0;
    while (!sb.done && guard < 200) begin
      send_packet();
      guard++;
    end

    // Register writes do not restart a finished image; further bytes give nothing.
    settle();
    set_regs(1'b0, 16'd1, 16'hffff);
    repeat (20) send_byte(8'($urandom_range(0, 255)));
    settle();

    if (sb.expected_runs.size() != 0) begin
      sb.mismatches++;
      $display("%0d expected runs never arrived", sb.expected_runs.size());
    end
    if (sb.mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[files.f]
design/rlerd_pkg.sv
design/rlerd_front.sv
design/rlerd_fifo.sv
design/rlerd_back.sv
design/rle_image_row_decoder.sv
tb/sv/tb_rle_image_row_decoder.sv
